// ===== rtl/rhps_pkg.sv =====
// rhps_pkg: constants, item kinds and modular helpers of the rolling-hash search
// used by the search top level; no dependencies
package rhps_pkg;

  localparam int MAX_PATTERN_DEF = 64;

  localparam logic [29:0] HASH_MOD  = 30'd1000000007;
  localparam logic [12:0] HASH_BASE = 13'd5689;
  localparam logic [7:0]  SYM_OFFSET = 8'd96;

  localparam logic [31:0] HASH_MOD2 = 32'(HASH_MOD) * 32'd2;
  localparam logic [31:0] HASH_MOD3 = 32'(HASH_MOD) * 32'd3;

  // bias that keeps value minus leaving term positive; leaving symbol lies in -96..159
  localparam logic [42:0] WIN_OFS = 43'(HASH_MOD) * 43'd160;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef logic [29:0] red_tbl_t [128];

  // entry j holds j * 2^shift mod M
  function automatic red_tbl_t build_red_tbl(input int shift);
    red_tbl_t t;
    longint unsigned unit;
    longint unsigned acc;
    unit = 64'd1;
    for (int i = 0; i < shift; i++) begin
      unit = unit * 64'd2;
      if (unit >= 64'(HASH_MOD)) unit = unit - 64'(HASH_MOD);
    end
    acc = 64'd0;
    for (int j = 0; j < 128; j++) begin
      t[j] = 30'(acc);
      acc = acc + unit;
      if (acc >= 64'(HASH_MOD)) acc = acc - 64'(HASH_MOD);
    end
    return t;
  endfunction

  localparam red_tbl_t RED_HI  = build_red_tbl(36);
  localparam red_tbl_t RED_MID = build_red_tbl(30);

  // x mod M for any 43-bit x: fold upper bits through tables, then trim
  function automatic logic [29:0] mod_reduce(input logic [42:0] x);
    logic [31:0] s;
    s = 32'(x[29:0]) + 32'(RED_HI[x[42:36]]) + 32'(RED_MID[{1'b0, x[35:30]}]);
    if (s >= HASH_MOD3) begin
      s = s - HASH_MOD3;
    end else if (s >= HASH_MOD2) begin
      s = s - HASH_MOD2;
    end else if (s >= 32'(HASH_MOD)) begin
      s = s - 32'(HASH_MOD);
    end
    return s[29:0];
  endfunction

  // (byte - 96) mod M
  function automatic logic [29:0] symbol_value(input logic [7:0] b);
    logic [29:0] v;
    if (b >= SYM_OFFSET) begin
      v = 30'(b - SYM_OFFSET);
    end else begin
      v = HASH_MOD - 30'(SYM_OFFSET - b);
    end
    return v;
  endfunction

endpackage

// ===== rtl/rhps_in_if.sv =====
// rhps_in_if: request channel into the rolling-hash search (kind and symbol)
// no dependencies
interface rhps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] symbol;

  modport source (output valid, output kind, output symbol, input ready);
  modport sink (input valid, input kind, input symbol, output ready);
endinterface

// ===== rtl/rhps_out_if.sv =====
// rhps_out_if: result channel of the rolling-hash search (match start position)
// no dependencies
interface rhps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_start;

  modport source (output valid, output match_start, input ready);
  modport sink (input valid, input match_start, output ready);
endinterface

// ===== rtl/rolling_hash_pattern_search.sv =====
// rolling_hash_pattern_search: polynomial rolling-hash pattern matcher, top level
// depends on rhps_pkg, rhps_in_if, rhps_out_if and rhps_ram
//
// Usage: in_chan carries requests of kind clear, pattern symbol or text symbol
// with a raw byte. A clear starts a new search; pattern symbols build the pattern
// hash; text symbols roll a window hash over the last pattern-length bytes, and
// on equal hashes a request with the 1-based window start goes out on out_chan.
// Throughput is one request per cycle of any kind while in_chan.ready is high. A match
// leaves on out_chan after its text symbol passes the delay-ring RAM read, the
// leaving-symbol product, its modular fold and the window-hash update, after
// which the output register holds the result. The window-hash update (multiply by
// the base and table fold) loops through the single register wh_r, which is what
// allows a text symbol every cycle while in_chan.ready is high.
// Reset clears the pattern, window and text-position state; the ring RAM is not
// cleared, and its read data is only used at entries written since the last clear.
// When out_chan stalls, the four pipeline stages keep filling and requests that
// give no result pass on; in_chan.ready drops once a waiting result blocks the
// last stage and every stage ahead of it is occupied.
module rolling_hash_pattern_search #(
  parameter int MAX_PATTERN = rhps_pkg::MAX_PATTERN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rhps_in_if.sink      in_chan,
  rhps_out_if.source   out_chan
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int DW = LW + 1;

  typedef struct packed {
    logic        clr;
    logic        need_sub;
    logic        elig;
    logic [8:0]  sym_val;
    logic [31:0] start;
    logic [29:0] ph;
    logic [29:0] bp;
  } stg_t;

  // search state
  logic [29:0]   ph_r, ph_nxt;
  logic [29:0]   bp_r, bp_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [29:0]   wh_r;

  // pipeline
  stg_t              s1_r, s2_r, s3_r, s4_r, s1_nxt;
  logic              v1_r, v2_r, v3_r, v4_r;
  logic              s1_enter;
  logic signed [39:0] p2_r, p_nxt;
  logic [29:0]       w3_r, w_nxt, h_nxt;
  logic signed [43:0] wsum;
  logic [8:0]        leave_val;
  logic              out_valid_r;
  logic [31:0]       out_start_r;

  logic              take1, take2, take3, take4;
  logic              out_free, hit4, in_fire;
  rhps_pkg::kind_t   kind;
  logic [31:0]       cnt_inc;
  logic [DW-1:0]     p_ext, l_ext, rd_ext;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  rhps_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (in_chan.symbol),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stage flow control
  always_comb begin
    out_free = !out_valid_r || out_chan.ready;
    hit4     = v4_r && !s4_r.clr && s4_r.elig && (wh_r == s4_r.ph);
    take4    = !v4_r || !hit4 || out_free;
    take3    = !v3_r || take4;
    take2    = !v2_r || take3;
    take1    = !v1_r || take2;
  end

  assign in_chan.ready        = take1;
  assign in_fire              = in_chan.valid && take1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.match_start = out_start_r;

  // accept stage: pattern state, ring access, text position
  always_comb begin
    kind      = rhps_pkg::kind_t'(in_chan.kind);
    ph_nxt    = ph_r;
    bp_nxt    = bp_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    s1_enter  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 32'd1;
    p_ext   = DW'(ptr_r);
    l_ext   = DW'(len_r);
    rd_ext  = (p_ext >= l_ext) ? p_ext - l_ext : p_ext + DW'(MAX_PATTERN) - l_ext;
    ram_raddr = rd_ext[AW-1:0];

    s1_nxt.clr      = 1'b0;
    s1_nxt.need_sub = (len_r != '0) && (cnt_r >= 32'(len_r));
    s1_nxt.elig     = (len_r != '0) && !ovf_r && (cnt_inc >= 32'(len_r));
    s1_nxt.sym_val  = {1'b0, in_chan.symbol} - {1'b0, rhps_pkg::SYM_OFFSET};
    s1_nxt.start    = cnt_inc - 32'(len_r) + 32'd1;
    s1_nxt.ph       = ph_r;
    s1_nxt.bp       = bp_r;

    if (in_fire) begin
      unique case (kind)
        rhps_pkg::KIND_CLEAR: begin
          ph_nxt     = '0;
          bp_nxt     = 30'd1;
          len_nxt    = '0;
          ovf_nxt    = 1'b0;
          cnt_nxt    = '0;
          ptr_nxt    = '0;
          s1_enter   = 1'b1;
          s1_nxt.clr = 1'b1;
        end
        rhps_pkg::KIND_PATTERN: begin
          if (cnt_r == '0) begin
            if (len_r >= LW'(MAX_PATTERN)) begin
              ovf_nxt = 1'b1;
            end else begin
              ph_nxt  = rhps_pkg::mod_reduce(43'(ph_r) * 43'(rhps_pkg::HASH_BASE)
                        + 43'(rhps_pkg::symbol_value(in_chan.symbol)));
              bp_nxt  = rhps_pkg::mod_reduce(43'(bp_r) * 43'(rhps_pkg::HASH_BASE));
              len_nxt = len_r + LW'(1);
            end
          end
        end
        rhps_pkg::KIND_TEXT: begin
          ram_we   = 1'b1;
          ram_re   = 1'b1;
          ptr_nxt  = (ptr_r == AW'(MAX_PATTERN - 1)) ? '0 : ptr_r + AW'(1);
          cnt_nxt  = cnt_inc;
          s1_enter = 1'b1;
        end
        rhps_pkg::KIND_NONE: begin
        end
      endcase
    end
  end

  // leaving-symbol term, its fold, and the window-hash step
  always_comb begin
    leave_val = {1'b0, ram_rdata} - {1'b0, rhps_pkg::SYM_OFFSET};
    p_nxt     = s1_r.need_sub ? 40'($signed(leave_val)) * 40'($signed({1'b0, s1_r.bp}))
                              : '0;
    wsum      = $signed({1'b0, rhps_pkg::WIN_OFS}) + 44'($signed(s2_r.sym_val)) - 44'(p2_r);
    w_nxt     = rhps_pkg::mod_reduce(wsum[42:0]);
    h_nxt     = rhps_pkg::mod_reduce(43'(wh_r) * 43'(rhps_pkg::HASH_BASE) + 43'(w3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= '0;
      bp_r        <= 30'd1;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      wh_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      bp_r  <= bp_nxt;
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
      if (take1) v1_r <= s1_enter;
      if (take2) v2_r <= v1_r;
      if (take3) v3_r <= v2_r;
      if (take4) begin
        v4_r <= v3_r;
        if (v3_r) wh_r <= s3_r.clr ? '0 : h_nxt;
      end
      if (out_free) out_valid_r <= hit4;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) s1_r <= s1_nxt;
    if (take2) begin
      s2_r <= s1_r;
      p2_r <= p_nxt;
    end
    if (take3) begin
      s3_r <= s2_r;
      w3_r <= w_nxt;
    end
    if (take4) s4_r <= s3_r;
    if (out_free) out_start_r <= s4_r.start;
  end

  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    wh_r < rhps_pkg::HASH_MOD)
    else $error("window hash out of range");

  a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r < rhps_pkg::HASH_MOD) && (bp_r < rhps_pkg::HASH_MOD))
    else $error("pattern hash or base power out of range");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_PATTERN))
    else $error("pattern length beyond ring depth");

  a_late_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (kind == rhps_pkg::KIND_PATTERN) && (cnt_r != '0))
    |=> (ph_r == $past(ph_r)) && (len_r == $past(len_r)))
    else $error("pattern symbol after text changed the pattern");

  a_hit_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    (hit4 && out_free) |=> (out_valid_r && (out_start_r == $past(s4_r.start))))
    else $error("matching window not presented on output");

endmodule

// ===== rtl/rhps_ram.sv =====
// rhps_ram: generic single-port-write, registered-read RAM, read-before-write
// no dependencies
module rhps_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
